[hdl/modinv_pkg.sv]
// Shared types and constants for the modular inverse block.
package modinv_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned RED_CNT_W = 6;
  localparam logic [RED_CNT_W-1:0] RED_LAST = RED_CNT_W'(VALUE_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_FIX,
    S_CHECK,
    S_ALIGN,
    S_SUB,
    S_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_REDUCE,
    OP_FIX,
    OP_INIT,
    OP_ALIGN,
    OP_SUB,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic b_zero;
    logic align_ok;
    logic k_zero;
  } dp_stat_t;

endpackage

[hdl/modinv_ctrl.sv]
// Sequencer for the reduction and Euclid steps of the modular inverse block.
module modinv_ctrl import modinv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o
);

  ctrl_state_e state_q, state_d;
  logic [RED_CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (start_i) state_d = S_REDUCE;
      end
      S_REDUCE: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == RED_LAST) state_d = S_FIX;
      end
      S_FIX: state_d = S_CHECK;
      S_CHECK: state_d = stat_i.b_zero ? S_DONE : S_ALIGN;
      S_ALIGN: begin
        if (!stat_i.align_ok) state_d = stat_i.k_zero ? S_CHECK : S_SUB;
      end
      S_SUB: begin
        if (stat_i.k_zero) state_d = S_CHECK;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_IDLE;
    unique case (state_q)
      S_IDLE:   cmd_o.op = start_i ? OP_LOAD : OP_IDLE;
      S_REDUCE: cmd_o.op = OP_REDUCE;
      S_FIX:    cmd_o.op = OP_FIX;
      S_CHECK:  cmd_o.op = stat_i.b_zero ? OP_IDLE : OP_INIT;
      S_ALIGN:  cmd_o.op = stat_i.align_ok ? OP_ALIGN : OP_SUB;
      S_SUB:    cmd_o.op = OP_SUB;
      S_DONE:   cmd_o.op = OP_FINISH;
      default:  cmd_o.op = OP_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

[hdl/modinv_dp.sv]
// Datapath of the modular inverse block: serial reduction and shift-subtract Euclid.
module modinv_dp import modinv_pkg::*; #(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic [MOD_BITS-1:0] modulus_i,
  output dp_stat_t            stat_o,
  output logic                valid_o,
  output logic [MOD_BITS-1:0] inverse_o,
  output logic                has_inverse_o
);

  localparam int unsigned CW = MOD_BITS + 2;
  localparam int unsigned KW = $clog2(MOD_BITS + 1);

  logic [MOD_BITS-1:0]   m_q, rem_q, a_q, b_q;
  logic [VALUE_W-1:0]    mag_q;
  logic                  neg_q;
  logic [MOD_BITS:0]     rs_q;
  logic signed [CW-1:0]  sa_q, sb_q, ss_q;
  logic [KW-1:0]         k_q;
  logic                  valid_q;
  logic [MOD_BITS-1:0]   inv_q;
  logic                  has_q;

  logic [MOD_BITS:0]     red_t, red_diff;
  logic                  red_ge;
  logic [MOD_BITS-1:0]   red_next, fix_a;
  logic                  sub_ge;
  logic [MOD_BITS:0]     sub_diff;
  logic [MOD_BITS-1:0]   a_new;
  logic signed [CW-1:0]  sa_new, m_ext, fin_s;
  logic [VALUE_W-1:0]    load_mag;

  assign red_t    = {rem_q, mag_q[VALUE_W-1]};
  assign red_ge   = (red_t >= {1'b0, m_q});
  assign red_diff = red_t - {1'b0, m_q};
  assign red_next = red_ge ? red_diff[MOD_BITS-1:0] : red_t[MOD_BITS-1:0];
  assign fix_a    = (neg_q && (rem_q != '0)) ? (m_q - rem_q) : rem_q;
  assign load_mag = value_i[VALUE_W-1] ? (~value_i + 1'b1) : value_i;

  assign sub_ge   = ({1'b0, a_q} >= rs_q);
  assign sub_diff = {1'b0, a_q} - rs_q;
  assign a_new    = sub_ge ? sub_diff[MOD_BITS-1:0] : a_q;
  assign sa_new   = sub_ge ? (sa_q - ss_q) : sa_q;

  assign m_ext = signed'({2'b00, m_q});

  always_comb begin
    if (sa_q < 0) begin
      fin_s = sa_q + m_ext;
    end else if (sa_q >= m_ext) begin
      fin_s = sa_q - m_ext;
    end else begin
      fin_s = sa_q;
    end
  end

  assign stat_o.b_zero   = (b_q == '0);
  assign stat_o.align_ok = ({rs_q[MOD_BITS-1:0], 1'b0} <= {1'b0, a_q});
  assign stat_o.k_zero   = (k_q == '0);

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        m_q   <= modulus_i;
        mag_q <= load_mag;
        neg_q <= value_i[VALUE_W-1];
        rem_q <= '0;
      end
      OP_REDUCE: begin
        rem_q <= red_next;
        mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
      end
      OP_FIX: begin
        a_q  <= fix_a;
        b_q  <= m_q;
        sa_q <= CW'(1);
        sb_q <= '0;
      end
      OP_INIT: begin
        rs_q <= {1'b0, b_q};
        ss_q <= sb_q;
        k_q  <= '0;
      end
      OP_ALIGN: begin
        rs_q <= {rs_q[MOD_BITS-1:0], 1'b0};
        ss_q <= ss_q <<< 1;
        k_q  <= k_q + 1'b1;
      end
      OP_SUB: begin
        if (k_q == '0) begin
          a_q  <= b_q;
          b_q  <= a_new;
          sa_q <= sb_q;
          sb_q <= sa_new;
        end else begin
          a_q  <= a_new;
          sa_q <= sa_new;
          rs_q <= rs_q >> 1;
          ss_q <= ss_q >>> 1;
          k_q  <= k_q - 1'b1;
        end
      end
      OP_FINISH: begin
        if ((m_q != '0) && (a_q == MOD_BITS'(1))) begin
          inv_q <= fin_s[MOD_BITS-1:0];
          has_q <= 1'b1;
        end else begin
          inv_q <= '0;
          has_q <= 1'b0;
        end
      end
      OP_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (cmd_i.op == OP_FINISH);
    end
  end

  assign valid_o       = valid_q;
  assign inverse_o     = inv_q;
  assign has_inverse_o = has_q;

endmodule

[hdl/modular_inverse_ext_euclid_top.sv]
// Top level of the modular inverse block: sequencer plus datapath.
// A request is taken when start_i is high while busy_o is low. The value is
// first reduced by a one-bit-per-cycle remainder unit over its 64 bits, and
// a sign correction step follows. The extended Euclidean algorithm then runs
// on one shared shift-and-subtract unit: each quotient costs a check step,
// the alignment shifts and a subtract step for each quotient bit, and one
// more check step and a finish step close the work. The result beat appears
// one cycle after the work ends: valid_o is high for exactly one cycle and
// cannot be stalled, so the receiver must take it then. A new request may be
// started in the cycle that the result is shown.
module modular_inverse_ext_euclid_top import modinv_pkg::*; #(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic [MOD_BITS-1:0] modulus_i,
  output logic                valid_o,
  output logic [MOD_BITS-1:0] inverse_o,
  output logic                has_inverse_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  modinv_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  modinv_dp #(
    .MOD_BITS(MOD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (value_i),
    .modulus_i    (modulus_i),
    .stat_o       (stat),
    .valid_o      (valid_o),
    .inverse_o    (inverse_o),
    .has_inverse_o(has_inverse_o)
  );

endmodule

[test/modular_inverse_ext_euclid_checker.sv]
// Checker for the modular inverse block: predicts each result and compares it with the output beat.
module modular_inverse_ext_euclid_checker import modinv_pkg::*; #(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic [MOD_BITS-1:0] modulus_i,
  input  logic                valid_i,
  input  logic [MOD_BITS-1:0] inverse_i,
  input  logic                has_inverse_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [MOD_BITS-1:0] inverse;
    logic                has_inverse;
  } inverse_result_t;

  inverse_result_t pending_inverses[$];
  int              mismatches;

  function automatic inverse_result_t predict_inverse(logic [VALUE_W-1:0] value,
                                                      logic [MOD_BITS-1:0] modulus);
    logic [63:0]     m;
    logic [63:0]     mag;
    logic [63:0]     rem;
    logic [63:0]     a;
    logic [63:0]     old_r;
    logic [63:0]     r;
    logic [63:0]     q;
    logic [63:0]     t;
    longint          old_s;
    longint          s;
    longint          s_next;
    inverse_result_t res;
    res = '0;
    m = 64'(modulus);
    if (m == 64'd0) begin
      return res;
    end
    if (value[63]) begin
      mag = ~value + 64'd1;
      rem = mag % m;
      a = (rem == 64'd0) ? 64'd0 : m - rem;
    end else begin
      a = value % m;
    end
    old_r = a;
    r = m;
    old_s = 1;
    s = 0;
    while (r != 64'd0) begin
      q = old_r / r;
      t = old_r - q * r;
      old_r = r;
      r = t;
      s_next = old_s - longint'(q) * s;
      old_s = s;
      s = s_next;
    end
    if (old_r != 64'd1) begin
      return res;
    end
    if (old_s < 0) begin
      mag = 64'(-old_s) % m;
      rem = (mag == 64'd0) ? 64'd0 : m - mag;
    end else begin
      rem = 64'(old_s) % m;
    end
    res.inverse = rem[MOD_BITS-1:0];
    res.has_inverse = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
  end

  // The result beat is checked before a request taken on the same edge is queued.
  always @(posedge clk_i or negedge rst_ni) begin
    inverse_result_t expected;
    if (!rst_ni) begin
      pending_inverses.delete();
    end else begin
      if (valid_i) begin
        if (pending_inverses.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending, inverse %0d has %0b",
                                    inverse_i, has_inverse_i));
        end else begin
          expected = pending_inverses.pop_front();
          if (inverse_i !== expected.inverse) begin
            report_mismatch($sformatf("inverse got %0d expected %0d",
                                      inverse_i, expected.inverse));
          end
          if (has_inverse_i !== expected.has_inverse) begin
            report_mismatch($sformatf("has_inverse got %0b expected %0b",
                                      has_inverse_i, expected.has_inverse));
          end
        end
      end
      if (start_i && !busy_i) begin
        pending_inverses.insert(pending_inverses.size(), predict_inverse(value_i, modulus_i));
      end
    end
    pending_o <= pending_inverses.size();
    fail_count_o <= mismatches;
  end

endmodule

[test/modular_inverse_ext_euclid_top_tb.sv]
// Testbench top for the modular inverse block: clock, reset, request stimulus and verdict.
module modular_inverse_ext_euclid_top_tb import modinv_pkg::*;;

  localparam int unsigned MOD_BITS = 31;
  localparam int unsigned RANDOM_ITEMS = 830;
  localparam int unsigned DRAIN_CYCLES = 64 + 6 * MOD_BITS + 16;
  localparam logic [MOD_BITS-1:0] MOD_MAX = '1;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 64'h7fff_ffff_ffff_ffff;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [VALUE_W-1:0]  value_i;
  logic [MOD_BITS-1:0] modulus_i;
  logic                valid_o;
  logic [MOD_BITS-1:0] inverse_o;
  logic                has_inverse_o;
  int                  fail_count;
  int                  pending_count;
  bit                  no_gaps;

  modular_inverse_ext_euclid_top #(
    .MOD_BITS(MOD_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .value_i      (value_i),
    .modulus_i    (modulus_i),
    .valid_o      (valid_o),
    .inverse_o    (inverse_o),
    .has_inverse_o(has_inverse_o)
  );

  modular_inverse_ext_euclid_checker #(
    .MOD_BITS(MOD_BITS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .value_i      (value_i),
    .modulus_i    (modulus_i),
    .valid_i      (valid_o),
    .inverse_i    (inverse_o),
    .has_inverse_i(has_inverse_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  // Each request beat waits a random gap unless a gapless stretch is running.
  task automatic send_request(input logic [VALUE_W-1:0] value,
                              input logic [MOD_BITS-1:0] modulus);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 39) == 0) begin
      no_gaps = !no_gaps;
    end
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= value;
    modulus_i <= modulus;
    do @(posedge clk_i); while (!(start_i && !busy_o));
  endtask

  function automatic logic [MOD_BITS-1:0] random_modulus();
    int unsigned         width;
    logic [MOD_BITS-1:0] m;
    width = ($urandom_range(0, 1) == 0) ? MOD_BITS : $urandom_range(1, MOD_BITS);
    m = MOD_BITS'($urandom) & (MOD_MAX >> (MOD_BITS - width));
    m[width-1] = 1'b1;
    return m;
  endfunction

  initial begin
    logic [VALUE_W-1:0]  value;
    logic [MOD_BITS-1:0] modulus;
    int unsigned         factor;
    start_i = 1'b0;
    value_i = '0;
    modulus_i = MOD_BITS'(1);
    rst_ni = 1'b0;
    no_gaps = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(64'd0, MOD_BITS'(1));
    send_request('1, MOD_BITS'(1));
    send_request(VALUE_MAX, MOD_BITS'(1));
    send_request(VALUE_MIN, MOD_BITS'(1));
    send_request(VALUE_MIN, '0);
    send_request(64'd5, '0);
    send_request(64'd1, MOD_MAX);
    send_request('1, MOD_MAX);
    send_request(VALUE_MAX, MOD_MAX);
    send_request(VALUE_MIN, MOD_MAX);
    send_request(64'd0, MOD_MAX);
    send_request(64'(MOD_MAX), MOD_MAX);
    send_request(-64'(MOD_MAX), MOD_MAX);
    send_request(64'(MOD_MAX) - 64'd1, MOD_MAX);
    send_request(64'd3, MOD_BITS'(7));
    send_request(-64'd3, MOD_BITS'(7));
    send_request(64'd2, MOD_BITS'(4));
    send_request(64'd6, MOD_BITS'(9));
    send_request(64'd1, MOD_BITS'(2));
    send_request('1, MOD_BITS'(2));
    send_request(VALUE_MAX, MOD_BITS'(1) << (MOD_BITS - 1));
    send_request(VALUE_MIN, MOD_BITS'(1) << (MOD_BITS - 1));
    send_request(64'd0, MOD_BITS'(5));

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      modulus = random_modulus();
      case ($urandom_range(0, 5))
        0, 1: begin
          value = {$urandom, $urandom};
        end
        2: begin
          value = 64'($signed($urandom_range(0, 2000)) - 1000);
        end
        3: begin
          value = 64'(modulus) * 64'($urandom);
          if ($urandom_range(0, 1) == 1) begin
            value = -value;
          end
        end
        4: begin
          factor = $urandom_range(2, 97);
          modulus = MOD_BITS'(factor * $urandom_range(1, 1 << 22));
          value = 64'(factor) * 64'($urandom);
          if ($urandom_range(0, 1) == 1) begin
            value = -value;
          end
        end
        default: begin
          value = 64'(modulus) * 64'($urandom_range(0, 1 << 20)) + 64'd1;
          if ($urandom_range(0, 1) == 1) begin
            value = -value;
          end
        end
      endcase
      if ($urandom_range(0, 59) == 0) begin
        modulus = '0;
      end
      send_request(value, modulus);
    end
    start_i <= 1'b0;

    do @(posedge clk_i); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
